### src/mnes_pkg.sv
// Package for the multitrack note event sequencer: shared constants, codes and types.
// No dependencies.
package mnes_pkg;

   localparam int TRACKS_DEF = 8;
   localparam int EVENTS_DEF = 256;
   localparam int TICKS_DEF = 96;
   localparam int TIME_BITS_DEF = 20;

   localparam int TS_W = 20;
   localparam int DELAY_W = 40;
   localparam logic [25:0] US_PER_MINUTE = 26'd60000000;
   localparam logic [7:0] PAUSE_NOTE = 8'hff;
   localparam logic [3:0] DRUM_CHANNEL = 4'd9;

   typedef enum logic [2:0] {
      KIND_CLEAR = 3'd0,
      KIND_NOTE  = 3'd1,
      KIND_PAUSE = 3'd2,
      KIND_STEP  = 3'd3,
      KIND_STOP  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      MSG_OFF  = 3'd0,
      MSG_ON   = 3'd1,
      MSG_REST = 3'd2,
      MSG_END  = 3'd3,
      MSG_STOP = 3'd4
   } msg_type;

   typedef enum logic [1:0] {
      REG_TEMPO     = 2'd0,
      REG_TRANSPOSE = 2'd1,
      REG_LOOP      = 2'd2,
      REG_CHANNELS  = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_EVT_RD,
      ST_EVT,
      ST_DIV,
      ST_EMIT_OFF,
      ST_EMIT_ON,
      ST_EMIT_REST,
      ST_EMIT_END,
      ST_STOP_SCAN,
      ST_EMIT_STOP,
      ST_WAIT
   } state_type;

   // start, busy and done between sequencer and divider
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

### src/mnes_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module mnes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and read one word a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### src/mnes_div.sv
// Serial restoring divider for the delay: one quotient bit a cycle, saturating result.
// Depends on mnes_pkg.
module mnes_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [45:0]                  numer,
   input  logic [19:0]                  denom,
   output mnes_pkg::div_ctl_type        ctl,
   output logic [mnes_pkg::DELAY_W-1:0] quot
);
   logic [45:0] num_ff, num_in;
   logic [20:0] rem_ff, rem_in;
   logic [45:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [20:0] trial;

   // shift one numerator bit into the remainder and try the subtract
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[19:0], num_ff[45]};
      if (start) begin
         num_in  = numer;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 6'd46;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[44:0], 1'b0};
         if (trial >= {1'b0, denom}) begin
            rem_in = trial - {1'b0, denom};
            q_in   = {q_ff[44:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[44:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quot = (q_ff[45:40] != 6'd0) ? {mnes_pkg::DELAY_W{1'b1}}
                                       : q_ff[mnes_pkg::DELAY_W-1:0];
endmodule

### src/multitrack_note_event_sequencer.sv
// Top level of the multitrack note event sequencer: sequencer, event RAM and delay divider.
// Depends on mnes_pkg, mnes_ram and mnes_div.
//
// Clear, appends and ignored kinds are handled in the idle state. A step scans the track
// heads one track at a time through the event RAM's single port (a read state and a
// compare state per track), then runs a serial division for the delay and hands out
// its result words; with looping at end of pass the scan runs twice. Stop walks the
// tracks once. A new word is taken only when the previous one is fully finished.
// There is no clearing pass: only entries below a track's fill count are ever used.
module multitrack_note_event_sequencer #(
   parameter int TRACKS = mnes_pkg::TRACKS_DEF,
   parameter int EVENTS_PER_TRACK = mnes_pkg::EVENTS_DEF,
   parameter int TICKS_PER_BEAT = mnes_pkg::TICKS_DEF,
   parameter int TIME_BITS = mnes_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_track,
   input  logic [19:0] req_timestamp,
   input  logic [6:0]  req_note,
   input  logic [6:0]  req_velocity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_message,
   output logic [3:0]  rsp_channel,
   output logic [7:0]  rsp_note_number,
   output logic [6:0]  rsp_note_velocity,
   output logic [39:0] rsp_delay_us,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int EW = $clog2(EVENTS_PER_TRACK);
   localparam int LW = EW + 1;
   localparam int AW = TW + EW;
   localparam int DEPTH = 1 << AW;
   localparam int RW = TIME_BITS + 15;
   localparam logic [19:0] TPB = 20'(TICKS_PER_BEAT);

   mnes_pkg::state_type st_ff, st_in;

   logic [8:0]  tempo_ff, tempo_in;
   logic [7:0]  transp_ff, transp_in;
   logic        loop_ff, loop_in;
   logic [31:0] chans_ff, chans_in;

   logic [LW-1:0] len_ff [TRACKS];
   logic [LW-1:0] pos_ff [TRACKS];
   logic          snd_v_ff [TRACKS];
   logic [7:0]    snd_n_ff [TRACKS];
   logic [TIME_BITS-1:0] now_ff, now_in;

   logic [TW-1:0] trk_ff, trk_in;
   logic          best_v_ff, best_v_in;
   logic [TW-1:0] best_ff, best_in;
   logic [TIME_BITS-1:0] best_ts_ff, best_ts_in;
   logic          looped_ff, looped_in;
   logic          first_ff, first_in;
   logic [39:0]   delay_ff, delay_in;
   logic [RW-1:0] evt_ff, evt_in;
   logic [7:0]    off_note_ff, off_note_in;

   logic        ov_ff, ov_in;
   logic [2:0]  om_ff, om_in;
   logic [3:0]  oc_ff, oc_in;
   logic [7:0]  on_ff, on_in;
   logic [6:0]  ovl_ff, ovl_in;
   logic [39:0] od_ff, od_in;
   logic        ol_ff, ol_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [RW-1:0] ram_wdata, ram_rdata;

   logic        div_start;
   logic [45:0] div_num;
   logic [19:0] div_den;
   mnes_pkg::div_ctl_type div_ctl;
   logic [39:0] div_q;

   logic [TIME_BITS-1:0] head_ts;
   logic [3:0] trk_ch, best_ch, app_ch;
   logic [7:0] app_note;
   logic [TIME_BITS-1:0] gap;
   logic [TIME_BITS-1:0] ev_ts;
   logic [7:0] ev_note;
   logic [6:0] ev_vel;
   logic [19:0] den_full;
   logic [TW-1:0] req_trk;
   logic any_len;

   // clear, rewind, append, play and stop strobes toward the per-track state
   logic do_clear, do_rewind, do_append, do_play, do_snd_off_all;
   logic [TW-1:0] stop_trk_clr;
   logic do_stop_clr;

   mnes_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   mnes_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_num),
      .denom(div_den), .ctl(div_ctl), .quot(div_q)
   );

   assign req_trk  = TW'(req_track);
   assign trk_ch   = 4'(chans_ff >> (4 * 32'(trk_ff)));
   assign best_ch  = 4'(chans_ff >> (4 * 32'(best_ff)));
   assign app_ch   = 4'(chans_ff >> (4 * 32'(req_trk)));
   assign app_note = (app_ch == mnes_pkg::DRUM_CHANNEL) ? {1'b0, req_note}
                                                        : {1'b0, req_note} + transp_ff;
   assign head_ts  = ram_rdata[RW-1:15];
   assign ev_ts    = evt_ff[RW-1:15];
   assign ev_note  = evt_ff[14:7];
   assign ev_vel   = evt_ff[6:0];
   assign gap      = ev_ts - now_ff;
   assign den_full = 20'((tempo_ff == 9'd0 ? 9'd1 : tempo_ff) * TPB);
   assign div_den  = den_full;
   // numerator carries the half-divisor rounding term
   assign div_num  = 46'(gap) * 46'(mnes_pkg::US_PER_MINUTE) + 46'(den_full >> 1);

   // configuration is taken whenever no word is in flight
   assign csr_ready = (st_ff == mnes_pkg::ST_IDLE);
   assign req_ready = (st_ff == mnes_pkg::ST_IDLE);

   // flag any track holding events, so a looped pass has something to play
   always_comb begin
      any_len = 1'b0;
      for (int i = 0; i < TRACKS; i++) begin
         if (len_ff[i] != '0) any_len = 1'b1;
      end
   end

   always_comb begin
      tempo_in  = tempo_ff;
      transp_in = transp_ff;
      loop_in   = loop_ff;
      chans_in  = chans_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mnes_pkg::REG_TEMPO:     tempo_in  = csr_data[8:0];
            mnes_pkg::REG_TRANSPOSE: transp_in = csr_data[7:0];
            mnes_pkg::REG_LOOP:      loop_in   = csr_data[0];
            mnes_pkg::REG_CHANNELS:  chans_in  = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer: next state, RAM access and result word
   always_comb begin
      st_in      = st_ff;
      trk_in     = trk_ff;
      best_v_in  = best_v_ff;
      best_in    = best_ff;
      best_ts_in = best_ts_ff;
      looped_in  = looped_ff;
      first_in   = first_ff;
      delay_in   = delay_ff;
      evt_in     = evt_ff;
      off_note_in = off_note_ff;
      now_in     = now_ff;
      ov_in  = ov_ff;
      om_in  = om_ff;
      oc_in  = oc_ff;
      on_in  = on_ff;
      ovl_in = ovl_ff;
      od_in  = od_ff;
      ol_in  = ol_ff;
      ram_we    = 1'b0;
      ram_addr  = {trk_ff, pos_ff[trk_ff][EW-1:0]};
      ram_wdata = {TIME_BITS'(req_timestamp), app_note, req_velocity};
      div_start = 1'b0;
      do_clear  = 1'b0;
      do_rewind = 1'b0;
      do_append = 1'b0;
      do_play   = 1'b0;
      do_snd_off_all = 1'b0;
      do_stop_clr  = 1'b0;
      stop_trk_clr = trk_ff;

      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end

      case (st_ff)
         mnes_pkg::ST_IDLE: begin
            if (req_valid) begin
               trk_in    = '0;
               best_v_in = 1'b0;
               looped_in = 1'b0;
               case (req_kind)
                  mnes_pkg::KIND_CLEAR: begin
                     do_clear  = 1'b1;
                     do_rewind = 1'b1;
                     now_in    = '0;
                  end
                  mnes_pkg::KIND_NOTE, mnes_pkg::KIND_PAUSE: begin
                     if (32'(req_track) < TRACKS
                         && 32'(len_ff[req_trk]) < EVENTS_PER_TRACK) begin
                        ram_addr = {req_trk, len_ff[req_trk][EW-1:0]};
                        ram_we   = 1'b1;
                        if (req_kind == mnes_pkg::KIND_PAUSE) begin
                           ram_wdata = {TIME_BITS'(req_timestamp), mnes_pkg::PAUSE_NOTE,
                                        7'd0};
                        end
                        do_append = 1'b1;
                     end
                  end
                  mnes_pkg::KIND_STEP: st_in = mnes_pkg::ST_SCAN_RD;
                  mnes_pkg::KIND_STOP: st_in = mnes_pkg::ST_STOP_SCAN;
                  default: ;
               endcase
            end
         end
         mnes_pkg::ST_SCAN_RD: begin
            // read head of the current track
            st_in = mnes_pkg::ST_SCAN;
         end
         mnes_pkg::ST_SCAN: begin
            if (pos_ff[trk_ff] < len_ff[trk_ff]
                && (!best_v_ff || head_ts < best_ts_ff)) begin
               best_v_in  = 1'b1;
               best_in    = trk_ff;
               best_ts_in = head_ts;
            end
            if (32'(trk_ff) == TRACKS - 1) begin
               trk_in = '0;
               st_in  = mnes_pkg::ST_EVT_RD;
            end else begin
               trk_in = trk_ff + TW'(1);
               st_in  = mnes_pkg::ST_SCAN_RD;
            end
         end
         mnes_pkg::ST_EVT_RD: begin
            if (!best_v_ff) begin
               st_in = mnes_pkg::ST_EMIT_END;
            end else begin
               ram_addr = {best_ff, pos_ff[best_ff][EW-1:0]};
               st_in    = mnes_pkg::ST_EVT;
            end
         end
         mnes_pkg::ST_EVT: begin
            evt_in = ram_rdata;
            st_in  = mnes_pkg::ST_DIV;
            first_in = 1'b1;
         end
         mnes_pkg::ST_DIV: begin
            if (!div_ctl.busy && !div_ctl.done && !first_ff) begin
               // not reached: divider started on entry
               div_start = 1'b1;
            end
            if (first_ff) begin
               div_start = 1'b1;
               first_in  = 1'b0;
            end else if (div_ctl.done) begin
               delay_in = (ev_ts > now_ff) ? div_q : 40'd0;
               now_in   = ev_ts;
               first_in = 1'b1;
               do_play  = 1'b1;
               // hold the note being silenced before the track takes the new one
               off_note_in = snd_n_ff[best_ff];
               if (snd_v_ff[best_ff]) st_in = mnes_pkg::ST_EMIT_OFF;
               else if (ev_vel != 7'd0) st_in = mnes_pkg::ST_EMIT_ON;
               else st_in = mnes_pkg::ST_EMIT_REST;
            end
         end
         mnes_pkg::ST_EMIT_OFF: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               om_in = mnes_pkg::MSG_OFF;
               oc_in = best_ch;
               on_in = off_note_ff;
               ovl_in = 7'd0;
               od_in = delay_ff;
               delay_in = 40'd0;
               ol_in = (ev_vel == 7'd0);
               st_in = (ev_vel == 7'd0) ? mnes_pkg::ST_WAIT : mnes_pkg::ST_EMIT_ON;
            end
         end
         mnes_pkg::ST_EMIT_ON: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               om_in = mnes_pkg::MSG_ON;
               oc_in = best_ch;
               on_in = ev_note;
               ovl_in = ev_vel;
               od_in = delay_ff;
               ol_in = 1'b1;
               st_in = mnes_pkg::ST_WAIT;
            end
         end
         mnes_pkg::ST_EMIT_REST: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               om_in = mnes_pkg::MSG_REST;
               oc_in = best_ch;
               on_in = 8'd0;
               ovl_in = 7'd0;
               od_in = delay_ff;
               ol_in = 1'b1;
               st_in = mnes_pkg::ST_WAIT;
            end
         end
         mnes_pkg::ST_EMIT_END: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               om_in = mnes_pkg::MSG_END;
               oc_in = 4'd0;
               on_in = 8'd0;
               ovl_in = 7'd0;
               od_in = 40'd0;
               do_rewind = 1'b1;
               now_in = '0;
               // loop on only when some track has an event to play again
               if (loop_ff && any_len && !looped_ff) begin
                  ol_in = 1'b0;
                  looped_in = 1'b1;
                  trk_in = '0;
                  best_v_in = 1'b0;
                  st_in = mnes_pkg::ST_SCAN_RD;
               end else begin
                  ol_in = 1'b1;
                  st_in = mnes_pkg::ST_WAIT;
               end
            end
         end
         mnes_pkg::ST_STOP_SCAN: begin
            if (!snd_v_ff[trk_ff] || !ov_ff || rsp_ready) begin
               if (snd_v_ff[trk_ff]) begin
                  ov_in = 1'b1;
                  om_in = mnes_pkg::MSG_OFF;
                  oc_in = trk_ch;
                  on_in = snd_n_ff[trk_ff];
                  ovl_in = 7'd0;
                  od_in = 40'd0;
                  ol_in = 1'b0;
                  do_stop_clr = 1'b1;
               end
               if (32'(trk_ff) == TRACKS - 1) st_in = mnes_pkg::ST_EMIT_STOP;
               else trk_in = trk_ff + TW'(1);
            end
         end
         mnes_pkg::ST_EMIT_STOP: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               om_in = mnes_pkg::MSG_STOP;
               oc_in = 4'd0;
               on_in = 8'd0;
               ovl_in = 7'd0;
               od_in = 40'd0;
               ol_in = 1'b1;
               do_rewind = 1'b1;
               now_in = '0;
               st_in = mnes_pkg::ST_WAIT;
            end
         end
         mnes_pkg::ST_WAIT: begin
            // hold until the final word is taken
            if (!ov_ff || rsp_ready) st_in = mnes_pkg::ST_IDLE;
         end
         default: st_in = mnes_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= mnes_pkg::ST_IDLE;
         tempo_ff  <= 9'd120;
         transp_ff <= 8'd0;
         loop_ff   <= 1'b0;
         chans_ff  <= '0;
         now_ff    <= '0;
         ov_ff     <= 1'b0;
         for (int i = 0; i < TRACKS; i++) begin
            len_ff[i]   <= '0;
            pos_ff[i]   <= '0;
            snd_v_ff[i] <= 1'b0;
         end
      end else begin
         st_ff     <= st_in;
         tempo_ff  <= tempo_in;
         transp_ff <= transp_in;
         loop_ff   <= loop_in;
         chans_ff  <= chans_in;
         now_ff    <= now_in;
         ov_ff     <= ov_in;
         for (int i = 0; i < TRACKS; i++) begin
            if (do_clear) len_ff[i] <= '0;
            else if (do_append && req_trk == TW'(i)) len_ff[i] <= len_ff[i] + LW'(1);
            if (do_rewind) pos_ff[i] <= '0;
            else if (do_play && best_ff == TW'(i)) pos_ff[i] <= pos_ff[i] + LW'(1);
            if ((do_snd_off_all) || (do_stop_clr && stop_trk_clr == TW'(i))) begin
               snd_v_ff[i] <= 1'b0;
            end else if (do_play && best_ff == TW'(i)) begin
               snd_v_ff[i] <= (ev_vel != 7'd0);
               snd_n_ff[i] <= ev_note;
            end
         end
      end
      trk_ff     <= trk_in;
      best_v_ff  <= best_v_in;
      best_ff    <= best_in;
      best_ts_ff <= best_ts_in;
      looped_ff  <= looped_in;
      first_ff   <= first_in;
      delay_ff   <= delay_in;
      evt_ff     <= evt_in;
      off_note_ff <= off_note_in;
      om_ff  <= om_in;
      oc_ff  <= oc_in;
      on_ff  <= on_in;
      ovl_ff <= ovl_in;
      od_ff  <= od_in;
      ol_ff  <= ol_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_message       = om_ff;
   assign rsp_channel       = oc_ff;
   assign rsp_note_number   = on_ff;
   assign rsp_note_velocity = ovl_ff;
   assign rsp_delay_us      = od_ff;
   assign rsp_last          = ol_ff;

   // a new word is never taken while a result is still owed
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != mnes_pkg::ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");
   // the divider only finishes inside the delay state
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_ctl.done |-> (st_ff == mnes_pkg::ST_DIV))
      else $error("divider finished outside delay phase");
   // velocity is zero on every word but note on
   a_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_message != mnes_pkg::MSG_ON) |-> (rsp_note_velocity == 7'd0))
      else $error("velocity on non note-on word");
endmodule
